@@ rtl/core/plce_pkg.sv @@
// Types and codes shared by the piecewise-linear curve evaluator.
// No dependencies; the core takes names from here by scope.
package plce_pkg;

    // Operation carried by an input word
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INTERP = 3'd0,
        ST_LOW    = 3'd1,
        ST_HIGH   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_NOSEG  = 3'd4
    } status_t;

    // Register index of points_in_use on the configuration port
    localparam logic REG_POINTS_IN_USE = 1'b0;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_WIDTH,
        S_DELTA,
        S_MAG,
        S_DIV,
        S_MULT,
        S_ADD
    } state_t;

    // Input word
    typedef struct packed {
        op_t                opcode;
        logic [3:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_value;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] curve_value;
        status_t            eval_status;
    } out_word_t;

endpackage

@@ rtl/core/plce_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module plce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/piecewise_linear_curve_eval.sv @@
// Clamped piecewise-linear curve evaluator: breakpoint RAM, scan and divide sequencer.
// Depends on plce_pkg (types, codes, states) and plce_ram (breakpoint store).
//
//  Channel   Handshake             Payload         Notes
//  command   start / busy          cmd             taken when start is high and busy low
//  result    done (one cycle)      result          receiver cannot stall
//  config    psel/penable/pwrite   paddr, pwdata   APB, pready tied high
//
// A breakpoint write leaves busy low. An evaluation on an empty table is answered
// from idle; a low clamp is answered from S_FIRST, a high clamp from S_LAST, and an
// interpolation after a scan for the segment through the single RAM read port, from
// S_WIDTH for a zero-width segment, else after the radix-2 divider, one quotient bit
// per cycle, and the multiply and add.
// Reset clears the sequencer and points_in_use; the table is undefined until written.
module piecewise_linear_curve_eval #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plce_pkg::in_word_t  cmd,
    output logic                done,
    output plce_pkg::out_word_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int NW  = (CW > 5) ? CW : 5;
    localparam int IW  = (AW > 4) ? AW : 4;
    localparam int QW  = FRAC_BITS + 1;
    localparam int DCW = $clog2(FRAC_BITS + 2);
    localparam int PW  = QW + 32;

    plce_pkg::state_t state_reg, state_next;

    logic [4:0]          points_in_use_reg;
    logic signed [31:0]  q_reg, q_next;
    logic [CW-1:0]       n_reg, n_next, n_eff, n_m1;
    logic [AW-1:0]       idx_reg, idx_next, last_addr, rd_addr, wr_addr;
    logic signed [31:0]  prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [31:0]  cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                ge_prev_reg, ge_prev_next;
    logic [32:0]         rem_reg, rem_next, trial;
    logic [32:0]         w_reg, w_next;
    logic                neg_reg, neg_next;
    logic [31:0]         mag_reg, mag_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [DCW-1:0]      div_cnt_reg, div_cnt_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [31:0]         step;
    logic                done_reg, done_next;
    logic signed [31:0]  value_reg, value_next;
    plce_pkg::status_t   status_reg, status_next;

    logic                accept, ram_we, slot_ok;
    logic [IW-1:0]       idx_wide;
    logic [63:0]         rd_data;
    logic signed [31:0]  rd_x, rd_y;

    // Shared add/subtract unit
    logic signed [33:0]  alu_a, alu_b, alu_res;
    logic                alu_sub;
    logic                alu_ge, alu_le, alu_zero;

    assign accept   = start && !busy;
    assign busy     = (state_reg != plce_pkg::S_IDLE);
    assign idx_wide = IW'(cmd.point_index);
    assign wr_addr  = idx_wide[AW-1:0];
    assign slot_ok  = (32'(cmd.point_index) < 32'(MAX_POINTS));
    assign ram_we   = accept && (cmd.opcode == plce_pkg::OP_WRITE) && slot_ok;
    assign rd_x     = rd_data[63:32];
    assign rd_y     = rd_data[31:0];

    // Clamp the point count to the table depth
    assign n_eff = (NW'(points_in_use_reg) > NW'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                               : CW'(points_in_use_reg);
    assign n_m1      = n_reg - CW'(1);
    assign last_addr = n_m1[AW-1:0];

    assign alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_ge   = !alu_res[33];
    assign alu_zero = (alu_res == '0);
    assign alu_le   = alu_res[33] || alu_zero;
    assign trial    = (div_cnt_reg == '0) ? rem_reg : {rem_reg[31:0], 1'b0};
    assign step     = prod_reg[FRAC_BITS+31:FRAC_BITS];

    plce_ram #(
        .WIDTH (64),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata ({cmd.point_x, cmd.point_y}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == plce_pkg::REG_POINTS_IN_USE) ? 32'(points_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_in_use_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == plce_pkg::REG_POINTS_IN_USE))
        begin
            points_in_use_reg <= pwdata[4:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plce_pkg::S_IDLE:
            begin
                if (accept && (cmd.opcode == plce_pkg::OP_EVAL) && (n_eff != '0))
                begin
                    state_next = plce_pkg::S_FIRST;
                end
            end
            plce_pkg::S_FIRST:
            begin
                state_next = alu_le ? plce_pkg::S_IDLE : plce_pkg::S_LAST;
            end
            plce_pkg::S_LAST:
            begin
                state_next = alu_ge ? plce_pkg::S_IDLE : plce_pkg::S_SCAN;
            end
            plce_pkg::S_SCAN:
            begin
                if (ge_prev_reg && alu_le)
                begin
                    state_next = plce_pkg::S_WIDTH;
                end
                else if (idx_reg == last_addr)
                begin
                    state_next = plce_pkg::S_IDLE;
                end
            end
            plce_pkg::S_WIDTH:
            begin
                state_next = alu_zero ? plce_pkg::S_IDLE : plce_pkg::S_DELTA;
            end
            plce_pkg::S_DELTA: state_next = plce_pkg::S_MAG;
            plce_pkg::S_MAG:   state_next = plce_pkg::S_DIV;
            plce_pkg::S_DIV:
            begin
                if (div_cnt_reg == DCW'(FRAC_BITS))
                begin
                    state_next = plce_pkg::S_MULT;
                end
            end
            plce_pkg::S_MULT:  state_next = plce_pkg::S_ADD;
            plce_pkg::S_ADD:   state_next = plce_pkg::S_IDLE;
            default:           state_next = plce_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM address and result word
    always_comb
    begin
        q_next       = q_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        ge_prev_next = ge_prev_reg;
        rem_next     = rem_reg;
        w_next       = w_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        prod_next    = prod_reg;
        done_next    = 1'b0;
        value_next   = value_reg;
        status_next  = status_reg;
        rd_addr      = idx_reg;
        alu_a        = 34'(q_reg);
        alu_b        = 34'(rd_x);
        alu_sub      = 1'b1;

        unique case (state_reg)
            plce_pkg::S_IDLE:
            begin
                // Latch the query, answer an empty table at once
                rd_addr = '0;
                if (accept && (cmd.opcode == plce_pkg::OP_EVAL))
                begin
                    q_next = cmd.query_value;
                    n_next = n_eff;
                    if (n_eff == '0)
                    begin
                        done_next   = 1'b1;
                        value_next  = '0;
                        status_next = plce_pkg::ST_EMPTY;
                    end
                end
            end
            plce_pkg::S_FIRST:
            begin
                // Clamp low, else keep slot 0 as the left end
                rd_addr      = last_addr;
                prev_x_next  = rd_x;
                prev_y_next  = rd_y;
                ge_prev_next = 1'b1;
                rem_next     = alu_res[32:0];
                if (alu_le)
                begin
                    done_next   = 1'b1;
                    value_next  = rd_y;
                    status_next = plce_pkg::ST_LOW;
                end
            end
            plce_pkg::S_LAST:
            begin
                // Clamp high, else start the scan at slot 1
                rd_addr  = AW'(1);
                idx_next = AW'(1);
                if (alu_ge)
                begin
                    done_next   = 1'b1;
                    value_next  = rd_y;
                    status_next = plce_pkg::ST_HIGH;
                end
            end
            plce_pkg::S_SCAN:
            begin
                if (ge_prev_reg && alu_le)
                begin
                    // Segment found: rem already holds query minus left x
                    cur_x_next = rd_x;
                    cur_y_next = rd_y;
                end
                else
                begin
                    prev_x_next  = rd_x;
                    prev_y_next  = rd_y;
                    ge_prev_next = alu_ge;
                    rem_next     = alu_res[32:0];
                    idx_next     = idx_reg + AW'(1);
                    rd_addr      = idx_reg + AW'(1);
                    if (idx_reg == last_addr)
                    begin
                        done_next   = 1'b1;
                        value_next  = '0;
                        status_next = plce_pkg::ST_NOSEG;
                    end
                end
            end
            plce_pkg::S_WIDTH:
            begin
                // Segment width; a zero-width segment gives its left y
                alu_a  = 34'(cur_x_reg);
                alu_b  = 34'(prev_x_reg);
                w_next = alu_res[32:0];
                if (alu_zero)
                begin
                    done_next   = 1'b1;
                    value_next  = prev_y_reg;
                    status_next = plce_pkg::ST_INTERP;
                end
            end
            plce_pkg::S_DELTA:
            begin
                // Sign of the rise
                alu_a    = 34'(cur_y_reg);
                alu_b    = 34'(prev_y_reg);
                neg_next = alu_res[33];
            end
            plce_pkg::S_MAG:
            begin
                // Magnitude of the rise, operands swapped when it falls
                alu_a        = neg_reg ? 34'(prev_y_reg) : 34'(cur_y_reg);
                alu_b        = neg_reg ? 34'(cur_y_reg) : 34'(prev_y_reg);
                mag_next     = alu_res[31:0];
                quo_next     = '0;
                div_cnt_next = '0;
            end
            plce_pkg::S_DIV:
            begin
                // One restoring-division step per cycle
                alu_a        = 34'(trial);
                alu_b        = 34'(w_reg);
                rem_next     = alu_ge ? alu_res[32:0] : trial;
                quo_next     = {quo_reg[QW-2:0], alu_ge};
                div_cnt_next = div_cnt_reg + DCW'(1);
            end
            plce_pkg::S_MULT:
            begin
                prod_next = quo_reg * mag_reg;
            end
            plce_pkg::S_ADD:
            begin
                // Apply the step to the left y and saturate
                alu_a       = 34'(prev_y_reg);
                alu_b       = {2'b00, step};
                alu_sub     = neg_reg;
                done_next   = 1'b1;
                status_next = plce_pkg::ST_INTERP;
                if (alu_res[33:31] == 3'b000 || alu_res[33:31] == 3'b111)
                begin
                    value_next = alu_res[31:0];
                end
                else
                begin
                    value_next = alu_res[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plce_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        ge_prev_reg <= ge_prev_next;
        rem_reg     <= rem_next;
        w_reg       <= w_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        prod_reg    <= prod_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
    end

    assign done               = done_reg;
    assign result.curve_value = value_reg;
    assign result.eval_status = status_reg;

    // Every evaluation that leaves the sequencer delivers a word
    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequencer returned to idle without a result word");

    // Remainder never exceeds the divisor while dividing
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plce_pkg::S_DIV) |-> (rem_reg <= w_reg))
        else $error("divider remainder above segment width");

    // Empty-table words come only from an evaluation taken with no points
    a_empty_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.eval_status == plce_pkg::ST_EMPTY)
        |-> $past(accept && cmd.opcode == plce_pkg::OP_EVAL && n_eff == '0))
        else $error("empty status without an empty-table evaluation");

    // Interpolated words come from the width check or the final add
    a_interp_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.eval_status == plce_pkg::ST_INTERP)
        |-> $past(state_reg == plce_pkg::S_ADD || state_reg == plce_pkg::S_WIDTH))
        else $error("interpolated status from an unexpected state");

endmodule
